/* hw/rtl/stable_merge_sorter_top_assert.svh */
// Assertion macros used by the checker of the stable merge sorter.
`ifndef STABLE_MERGE_SORTER_TOP_ASSERT_SVH
`define STABLE_MERGE_SORTER_TOP_ASSERT_SVH

// General clocked assertion, switched off while reset is asserted.
`define SMS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A stalled signal keeps its value until the transfer completes.
`define SMS_HOLD(lbl, vld, rdy, sig, msg) \
    `SMS_ASSERT(lbl, ((vld) && !(rdy)) |=> $stable(sig), msg)

`endif

/* hw/rtl/sms_pkg.sv */
// Package with the shared constants and controller/datapath interface types of the sorter.
`default_nettype none

package sms_pkg;

    localparam int MAX_ELEMENTS_DEF = 64;
    localparam int DATA_W           = 32;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_phase;
        logic sort_start;
        logic seg_init;
        logic merge_step;
        logic seg_next;
        logic out_phase;
        logic out_load;
    } sms_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic close_set;
        logic n_ge2;
        logic seg_last;
        logic sort_done;
        logic out_free;
        logic out_is_last;
    } sms_sts_t;

endpackage

`default_nettype wire

/* hw/rtl/stable_merge_sorter_top.sv */
// Top level of the stable merge sorter: controller and datapath joined by command and status.
//
// Channel  Dir  tdata            tuser    tlast      Meaning
// s_*      in   value[31:0]      -        last       one signed element of the set
// m_*      out  sorted_value     dropped  last_res   next element in ascending order
//
// The set is stored while s_tready is high.
// The transfer marked with tlast closes the set. A bottom-up merge sort then
// runs ceil(log2 n) passes between two memories; each element of a pass is read
// and then written, and each pair of runs is set up and closed in states of its own.
// Output reads each result and then loads it into the output register; stalls
// on m_tready hold the load. Reset clears counters and control; memory contents
// are not cleared as only entries of the open set are read. Values beyond
// MAX_ELEMENTS are discarded and every result of that set carries tuser high.
`default_nettype none

module stable_merge_sorter_top #(
    parameter int MAX_ELEMENTS = sms_pkg::MAX_ELEMENTS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] value
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // [31:0] sorted_value
    output logic             m_tlast,
    output logic             m_tuser    // [0] dropped
);

    // The controller only sequences; every counter and memory sits in the datapath.
    sms_pkg::sms_cmd_t cmd;
    sms_pkg::sms_sts_t sts;

    sms_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    sms_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

/* hw/rtl/sms_ram.sv */
// Generic RAM with one write port and two registered read ports.
`default_nettype none

module sms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_a <= mem_reg[raddr_a];
        rdata_b <= mem_reg[raddr_b];
    end

endmodule

`default_nettype wire

/* hw/rtl/sms_ctrl.sv */
// Controller state machine that sequences loading, merge passes and output of the sorter.
`default_nettype none

module sms_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire sms_pkg::sms_sts_t sts,
    output sms_pkg::sms_cmd_t     cmd
);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SORT_START,
        ST_SEG_INIT,
        ST_MERGE_RD,
        ST_MERGE_WR,
        ST_SEG_NEXT,
        ST_OUT_RD,
        ST_OUT_LD
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (sts.close_set)
                begin
                    state_next = ST_SORT_START;
                end
            end
            ST_SORT_START:
            begin
                state_next = sts.n_ge2 ? ST_SEG_INIT : ST_OUT_RD;
            end
            ST_SEG_INIT:
            begin
                state_next = ST_MERGE_RD;
            end
            ST_MERGE_RD:
            begin
                state_next = ST_MERGE_WR;
            end
            ST_MERGE_WR:
            begin
                state_next = sts.seg_last ? ST_SEG_NEXT : ST_MERGE_RD;
            end
            ST_SEG_NEXT:
            begin
                state_next = sts.sort_done ? ST_OUT_RD : ST_SEG_INIT;
            end
            ST_OUT_RD:
            begin
                state_next = ST_OUT_LD;
            end
            ST_OUT_LD:
            begin
                if (sts.out_free)
                begin
                    state_next = sts.out_is_last ? ST_LOAD : ST_OUT_RD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd            = '0;
        cmd.load_phase = (state_reg == ST_LOAD);
        cmd.sort_start = (state_reg == ST_SORT_START);
        cmd.seg_init   = (state_reg == ST_SEG_INIT);
        cmd.merge_step = (state_reg == ST_MERGE_WR);
        cmd.seg_next   = (state_reg == ST_SEG_NEXT);
        cmd.out_phase  = (state_reg == ST_OUT_RD) || (state_reg == ST_OUT_LD);
        cmd.out_load   = (state_reg == ST_OUT_LD) && sts.out_free;
    end

endmodule

`default_nettype wire

/* hw/rtl/sms_datapath.sv */
// Datapath of the sorter: element memories, run pointers, merge compare and output register.
`default_nettype none

module sms_datapath #(
    parameter int MAX_ELEMENTS = sms_pkg::MAX_ELEMENTS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire sms_pkg::sms_cmd_t         cmd,
    output sms_pkg::sms_sts_t              sts,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [sms_pkg::DATA_W-1:0] s_tdata,
    input  wire logic                      s_tlast,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic      [sms_pkg::DATA_W-1:0] m_tdata,
    output logic                           m_tlast,
    output logic                           m_tuser
);

    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int PW = AW + 1;
    localparam int SW = PW + 2;
    localparam int DW = sms_pkg::DATA_W;

    logic [PW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic [PW-1:0] w_reg, w_next;
    logic [PW-1:0] lo_reg, lo_next;
    logic [PW-1:0] mid_reg, mid_next;
    logic [PW-1:0] hi_reg, hi_next;
    logic [PW-1:0] i_reg, i_next;
    logic [PW-1:0] j_reg, j_next;
    logic [PW-1:0] k_reg, k_next;
    logic [PW-1:0] o_reg, o_next;
    logic          src_reg, src_next;
    logic          mval_reg, mval_next;
    logic [DW-1:0] mdata_reg;
    logic          mlast_reg;
    logic          mdrop_reg;

    logic          in_fire;
    logic          store_en;
    logic          take_left;
    logic [DW-1:0] merge_data;
    logic [DW-1:0] da, db;
    logic [DW-1:0] a_rda, a_rdb, b_rda, b_rdb;
    logic [AW-1:0] raddr_a;
    logic          a_we, b_we;
    logic [AW-1:0] a_waddr;
    logic [DW-1:0] a_wdata;
    logic [SW-1:0] n_ext, lw_sum, l2w_sum, w2_ext;
    logic [PW-1:0] mid_calc, hi_calc;

    assign s_tready = cmd.load_phase;
    assign in_fire  = s_tvalid && s_tready;
    assign store_en = in_fire && (count_reg < PW'(MAX_ELEMENTS));

    // Source memory of the current pass is selected by src_reg, the other one is written.
    assign da = src_reg ? b_rda : a_rda;
    assign db = src_reg ? b_rdb : a_rdb;

    assign take_left  = (i_reg < mid_reg) &&
                        ((j_reg >= hi_reg) || ($signed(da) <= $signed(db)));
    assign merge_data = take_left ? da : db;

    assign raddr_a = cmd.out_phase ? o_reg[AW-1:0] : i_reg[AW-1:0];

    assign a_we    = store_en || (cmd.merge_step && src_reg);
    assign a_waddr = store_en ? count_reg[AW-1:0] : k_reg[AW-1:0];
    assign a_wdata = store_en ? s_tdata : merge_data;
    assign b_we    = cmd.merge_step && !src_reg;

    sms_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_ELEMENTS)
    ) u_element_ram (
        .clk     (clk),
        .we      (a_we),
        .waddr   (a_waddr),
        .wdata   (a_wdata),
        .raddr_a (raddr_a),
        .raddr_b (j_reg[AW-1:0]),
        .rdata_a (a_rda),
        .rdata_b (a_rdb)
    );

    sms_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_ELEMENTS)
    ) u_scratch_ram (
        .clk     (clk),
        .we      (b_we),
        .waddr   (k_reg[AW-1:0]),
        .wdata   (merge_data),
        .raddr_a (raddr_a),
        .raddr_b (j_reg[AW-1:0]),
        .rdata_a (b_rda),
        .rdata_b (b_rdb)
    );

    // Run boundaries, clamped to the number of stored elements.
    assign n_ext    = SW'(count_reg);
    assign w2_ext   = SW'(w_reg) << 1;
    assign lw_sum   = SW'(lo_reg) + SW'(w_reg);
    assign l2w_sum  = SW'(lo_reg) + w2_ext;
    assign mid_calc = (lw_sum >= n_ext) ? count_reg : lw_sum[PW-1:0];
    assign hi_calc  = (l2w_sum >= n_ext) ? count_reg : l2w_sum[PW-1:0];

    always_comb
    begin
        sts             = '0;
        sts.close_set   = in_fire && s_tlast;
        sts.n_ge2       = (count_reg >= PW'(2));
        sts.seg_last    = ((k_reg + PW'(1)) == hi_reg);
        sts.sort_done   = (l2w_sum >= n_ext) && (w2_ext >= n_ext);
        sts.out_free    = !mval_reg || m_tready;
        sts.out_is_last = ((o_reg + PW'(1)) == count_reg);
    end

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        w_next     = w_reg;
        lo_next    = lo_reg;
        mid_next   = mid_reg;
        hi_next    = hi_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        o_next     = o_reg;
        src_next   = src_reg;
        mval_next  = (mval_reg && !m_tready);

        if (in_fire)
        begin
            if (store_en)
            begin
                count_next = count_reg + PW'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end

        if (cmd.sort_start)
        begin
            w_next   = PW'(1);
            lo_next  = '0;
            o_next   = '0;
            src_next = 1'b0;
        end

        if (cmd.seg_init)
        begin
            mid_next = mid_calc;
            hi_next  = hi_calc;
            i_next   = lo_reg;
            j_next   = mid_calc;
            k_next   = lo_reg;
        end

        if (cmd.merge_step)
        begin
            k_next = k_reg + PW'(1);
            if (take_left)
            begin
                i_next = i_reg + PW'(1);
            end
            else
            begin
                j_next = j_reg + PW'(1);
            end
        end

        if (cmd.seg_next)
        begin
            if (l2w_sum >= n_ext)
            begin
                lo_next  = '0;
                w_next   = w_reg << 1;
                src_next = !src_reg;
            end
            else
            begin
                lo_next = l2w_sum[PW-1:0];
            end
        end

        if (cmd.out_load)
        begin
            mval_next = 1'b1;
            o_next    = o_reg + PW'(1);
            if (sts.out_is_last)
            begin
                count_next = '0;
                ovf_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            w_reg     <= '0;
            lo_reg    <= '0;
            mid_reg   <= '0;
            hi_reg    <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            o_reg     <= '0;
            src_reg   <= 1'b0;
            mval_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            w_reg     <= w_next;
            lo_reg    <= lo_next;
            mid_reg   <= mid_next;
            hi_reg    <= hi_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            o_reg     <= o_next;
            src_reg   <= src_next;
            mval_reg  <= mval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            mdata_reg <= da;
            mlast_reg <= sts.out_is_last;
            mdrop_reg <= ovf_reg;
        end
    end

    assign m_tvalid = mval_reg;
    assign m_tdata  = mdata_reg;
    assign m_tlast  = mlast_reg;
    assign m_tuser  = mdrop_reg;

endmodule

`default_nettype wire

/* hw/rtl/sms_checker.sv */
// Port-level checker of the sorter and its bind to the top level.
`default_nettype none

`include "stable_merge_sorter_top_assert.svh"

module sms_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        m_tlast,
    input wire logic        m_tuser
);

    `SMS_HOLD(a_m_valid_hold, m_tvalid, m_tready, m_tvalid, "m_tvalid dropped while stalled")
    `SMS_HOLD(a_m_data_hold, m_tvalid, m_tready, m_tdata, "m_tdata changed while stalled")
    `SMS_ASSERT(a_no_input_mid_set, (m_tvalid && !m_tlast) |-> !s_tready, "input taken mid-output")
    `SMS_ASSERT(a_drop_flag_steady, (m_tvalid && m_tready && !m_tlast) |=> (!m_tvalid || (m_tuser == $past(m_tuser))), "dropped flag changed within a set")

endmodule

bind stable_merge_sorter_top sms_checker u_sms_checker (.*);

`default_nettype wire
